// ===== rtl/owm_pkg.sv =====
// ----------------------------------------------------------------------------
// owm_pkg
// Types and constants shared by the one-wire bus master core.
// ----------------------------------------------------------------------------
`default_nettype none

package owm_pkg;

	localparam int CFG_WIDTH = 10;
	localparam int CFG_COUNT = 8;
	localparam int CFG_INDEX_WIDTH = 3;

	// register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RESET_RECOVER = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_WRITE_LOW     = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_WRITE_HOLD    = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_READ_LOW      = 3'd5;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_READ_SAMPLE   = 3'd6;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_READ_RECOVER  = 3'd7;

	// register reset values, in ticks
	localparam logic [CFG_WIDTH-1:0] RST_RESET_LOW     = 10'd500;
	localparam logic [CFG_WIDTH-1:0] RST_PRESENCE_WAIT = 10'd70;
	localparam logic [CFG_WIDTH-1:0] RST_RESET_RECOVER = 10'd500;
	localparam logic [CFG_WIDTH-1:0] RST_WRITE_LOW     = 10'd10;
	localparam logic [CFG_WIDTH-1:0] RST_WRITE_HOLD    = 10'd50;
	localparam logic [CFG_WIDTH-1:0] RST_READ_LOW      = 10'd5;
	localparam logic [CFG_WIDTH-1:0] RST_READ_SAMPLE   = 10'd5;
	localparam logic [CFG_WIDTH-1:0] RST_READ_RECOVER  = 10'd50;

	// command codes
	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_RESET = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_LOW     = 3'd1,
		PH_HOLD    = 3'd2,
		PH_WAIT    = 3'd3,
		PH_RECOVER = 3'd4
	} phase_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] reset_low;
		logic [CFG_WIDTH-1:0] presence_wait;
		logic [CFG_WIDTH-1:0] reset_recover;
		logic [CFG_WIDTH-1:0] write_low;
		logic [CFG_WIDTH-1:0] write_hold;
		logic [CFG_WIDTH-1:0] read_low;
		logic [CFG_WIDTH-1:0] read_sample;
		logic [CFG_WIDTH-1:0] read_recover;
	} cfg_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy;
		logic       done;
		logic       presence;
		logic [7:0] rx_byte;
	} result_t;

	// a zero length behaves as one tick
	function automatic logic [CFG_WIDTH-1:0] span(input logic [CFG_WIDTH-1:0] v);
		span = (v == '0) ? CFG_WIDTH'(1) : v;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/owm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// owm_cfg_regs
// Timing register file, written through a valid/ready port.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_cfg_regs
	import owm_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr_en,
	input  wire logic [CFG_INDEX_WIDTH-1:0] wr_index,
	input  wire logic [CFG_WIDTH-1:0]       wr_data,
	output cfg_t                            cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low     <= RST_RESET_LOW;
			cfg_q.presence_wait <= RST_PRESENCE_WAIT;
			cfg_q.reset_recover <= RST_RESET_RECOVER;
			cfg_q.write_low     <= RST_WRITE_LOW;
			cfg_q.write_hold    <= RST_WRITE_HOLD;
			cfg_q.read_low      <= RST_READ_LOW;
			cfg_q.read_sample   <= RST_READ_SAMPLE;
			cfg_q.read_recover  <= RST_READ_RECOVER;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RESET_LOW:     cfg_q.reset_low     <= wr_data;
				REG_PRESENCE_WAIT: cfg_q.presence_wait <= wr_data;
				REG_RESET_RECOVER: cfg_q.reset_recover <= wr_data;
				REG_WRITE_LOW:     cfg_q.write_low     <= wr_data;
				REG_WRITE_HOLD:    cfg_q.write_hold    <= wr_data;
				REG_READ_LOW:      cfg_q.read_low      <= wr_data;
				REG_READ_SAMPLE:   cfg_q.read_sample   <= wr_data;
				REG_READ_RECOVER:  cfg_q.read_recover  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/owm_engine.sv =====
// ----------------------------------------------------------------------------
// owm_engine
// Bus timing state machine: one tick per step, gives the tick's result.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_engine
	import owm_pkg::*;
#(
	parameter int TICK_COUNT_WIDTH = 10
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [1:0] action,
	input  wire logic [7:0] tx_byte,
	input  wire logic       line_level,
	input  wire cfg_t       cfg,
	output result_t         res
);

	localparam int CW = ((TICK_COUNT_WIDTH > CFG_WIDTH) ? TICK_COUNT_WIDTH : CFG_WIDTH) + 1;

	phase_t                      ph_q, ph_n, ph_cur;
	logic [TICK_COUNT_WIDTH-1:0] tick_q, tick_n, tick_cur;
	logic [2:0]                  bit_q, bit_n, bit_cur;
	logic [1:0]                  kind_q, kind_n;
	logic [7:0]                  shift_q, shift_n;
	logic                        pres_q, pres_n;
	logic [7:0]                  read_q, read_n;
	logic                        drive, done, is_reset, is_write;
	logic [CFG_WIDTH-1:0]        len;
	logic [CW-1:0]               tick_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			kind_q  <= ACT_NONE;
			shift_q <= '0;
			pres_q  <= 1'b1;
			read_q  <= '0;
		end else if (step) begin
			ph_q    <= ph_n;
			tick_q  <= tick_n;
			bit_q   <= bit_n;
			kind_q  <= kind_n;
			shift_q <= shift_n;
			pres_q  <= pres_n;
			read_q  <= read_n;
		end
	end

	always_comb begin
		ph_cur   = ph_q;
		tick_cur = tick_q;
		bit_cur  = bit_q;
		kind_n   = kind_q;
		shift_n  = shift_q;
		pres_n   = pres_q;
		read_n   = read_q;
		drive    = 1'b0;
		done     = 1'b0;
		len      = CFG_WIDTH'(1);

		// command taken only from idle; the accepting tick is the first low tick
		if (ph_q == PH_IDLE && action != ACT_NONE) begin
			kind_n   = action;
			shift_n  = (action == ACT_WRITE) ? tx_byte : 8'h00;
			bit_cur  = '0;
			tick_cur = '0;
			ph_cur   = PH_LOW;
		end

		is_reset = (kind_n == ACT_RESET);
		is_write = (kind_n == ACT_WRITE);

		unique case (ph_cur)
			PH_LOW: begin
				drive = 1'b1;
				len   = is_reset ? span(cfg.reset_low) :
					(is_write ? span(cfg.write_low) : span(cfg.read_low));
			end
			PH_HOLD: begin
				drive = ~shift_n[bit_cur];
				len   = span(cfg.write_hold);
			end
			PH_WAIT: begin
				len = is_reset ? span(cfg.presence_wait) : span(cfg.read_sample);
			end
			PH_RECOVER: begin
				len = is_reset ? span(cfg.reset_recover) : span(cfg.read_recover);
				// sample on the first recovery tick
				if (tick_cur == '0) begin
					if (is_reset)
						pres_n = line_level;
					else
						shift_n[bit_cur] = shift_n[bit_cur] | line_level;
				end
			end
			default: ;
		endcase

		ph_n     = ph_cur;
		tick_n   = tick_cur;
		bit_n    = bit_cur;
		tick_inc = CW'(tick_cur) + CW'(1);

		if (ph_cur != PH_IDLE && ph_cur != PH_LOW && ph_cur != PH_HOLD &&
				ph_cur != PH_WAIT && ph_cur != PH_RECOVER) begin
			ph_n = PH_IDLE;
		end else if (ph_cur != PH_IDLE) begin
			if (tick_inc < CW'(len) && tick_cur != '1) begin
				tick_n = tick_inc[TICK_COUNT_WIDTH-1:0];
			end else begin
				tick_n = '0;
				unique case (ph_cur)
					PH_LOW:  ph_n = is_write ? PH_HOLD : PH_WAIT;
					PH_HOLD: begin
						if (bit_cur == 3'd7) begin
							ph_n = PH_IDLE;
							done = 1'b1;
						end else begin
							bit_n = bit_cur + 3'd1;
							ph_n  = PH_LOW;
						end
					end
					PH_WAIT: ph_n = PH_RECOVER;
					default: begin
						if (is_reset) begin
							ph_n = PH_IDLE;
							done = 1'b1;
						end else if (bit_cur == 3'd7) begin
							read_n = shift_n;
							ph_n   = PH_IDLE;
							done   = 1'b1;
						end else begin
							bit_n = bit_cur + 3'd1;
							ph_n  = PH_LOW;
						end
					end
				endcase
			end
		end

		res.drive_low = drive;
		res.busy      = (ph_n != PH_IDLE);
		res.done      = done;
		res.presence  = pres_n;
		res.rx_byte   = read_n;
	end

endmodule

`default_nettype wire

// ===== rtl/one_wire_bus_master_core.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master_core
// One-wire bus master with reset/presence, byte write and byte read commands.
// ----------------------------------------------------------------------------
// Usage:
//   Every request on the input channel is one bus tick (normally 1 us) and
//   carries action, tx_byte and the sampled line_level. Each request gives
//   exactly one result: drive_low for that tick, busy_res, done_res, the last
//   presence_level and the rx_byte of the last completed read.
//   Commands (reset, write byte, read byte) are taken only while idle; a
//   command sent while busy is dropped. Phase lengths come from eight timing
//   registers written over the cfg port (cfg_ready is always high); write
//   them only while the core is idle.
//   A request is held in the input register, and its result is registered in
//   the output register. Throughput: one request per clock cycle while
//   out_stall is low, as the timing state machine steps once per request.
//   When out_stall is held the result register holds its value, the input
//   register fills and in_stall rises in the same cycle; nothing is lost.
//   Reset (arst_n low) empties both registers, returns the timing registers
//   to their defaults and the state machine to idle with presence at one.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master_core
	import owm_pkg::*;
#(
	parameter int TICK_COUNT_WIDTH = 10
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [1:0]                 action,
	input  wire logic [7:0]                 tx_byte,
	input  wire logic                       line_level,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            drive_low,
	output logic                            busy_res,
	output logic                            done_res,
	output logic                            presence_level,
	output logic [7:0]                      rx_byte,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [CFG_WIDTH-1:0]       cfg_data
);

	cfg_t       cfg;
	result_t    res;
	result_t    res_q;
	logic       valid_s1, out_valid_q;
	logic [1:0] action_s1;
	logic [7:0] tx_byte_s1;
	logic       line_s1;
	logic       out_load, advance, accept;

	assign cfg_ready = 1'b1;
	assign out_load  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_load;
	assign in_stall  = valid_s1 && !out_load;
	assign accept    = in_valid && !in_stall;

	owm_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	owm_engine #(
		.TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.action     (action_s1),
		.tx_byte    (tx_byte_s1),
		.line_level (line_s1),
		.cfg        (cfg),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1  <= action;
			tx_byte_s1 <= tx_byte;
			line_s1    <= line_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign drive_low      = res_q.drive_low;
	assign busy_res       = res_q.busy;
	assign done_res       = res_q.done;
	assign presence_level = res_q.presence;
	assign rx_byte        = res_q.rx_byte;

endmodule

`default_nettype wire

// ===== rtl/owm_checker.sv =====
// ----------------------------------------------------------------------------
// owm_checker
// Port-level checks for the one-wire bus master core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic drive_low,
	input wire logic busy_res,
	input wire logic done_res
);

	// a finished command is no longer busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done_res with busy_res set");

	// the bus is only pulled low while a command runs
	a_drive_in_command: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_low |-> busy_res || done_res)
		else $error("drive_low outside a command");

	// input backs up only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall without a stalled result");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

endmodule

bind one_wire_bus_master_core owm_checker u_owm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.drive_low (drive_low),
	.busy_res  (busy_res),
	.done_res  (done_res)
);

`default_nettype wire

// ===== verif/tb_one_wire_bus_master_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master_core
// Self-checking bench for the one-wire bus master core. Every request is one
// bus tick. A tick-level predictor runs alongside the core, and each result is
// checked against it in order. A short table of directed commands runs first,
// over default, shortest and random timings. Random command streams follow,
// with random stalls on both channels, then without stalls.
// ----------------------------------------------------------------------------

module tb_one_wire_bus_master_core;
	import owm_pkg::*;

	localparam int TICK_W = 10;
	localparam int TICK_MAX = (1 << TICK_W) - 1;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DIR_ROWS = 14;

	typedef enum logic [1:0] {
		TIM_KEEP,
		TIM_ZERO,
		TIM_MAX,
		TIM_RANDOM
	} timing_sel_t;

	typedef struct packed {
		timing_sel_t sel;
		logic [1:0]  act;
		logic [7:0]  tx;
		logic [7:0]  pat;    // bus level per slot, bit 0 also used for presence
		bit          typed;
		logic        t_pres;
		logic [7:0]  t_rx;
	} dir_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [1:0]                 action;
	logic [7:0]                 tx_byte;
	logic                       line_level;
	logic                       out_valid;
	logic                       out_stall;
	logic                       drive_low;
	logic                       busy_res;
	logic                       done_res;
	logic                       presence_level;
	logic [7:0]                 rx_byte;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_WIDTH-1:0]       cfg_data;

	// shadow of the core's bus timing state
	logic [CFG_WIDTH-1:0] tim_reg [CFG_COUNT];
	phase_t               bus_ph = PH_IDLE;
	int                   tick_cnt = 0;
	logic [2:0]           slot_bit = '0;
	logic [1:0]           cmd_kind = ACT_NONE;
	logic [7:0]           shift_reg = '0;
	logic                 pres_reg = 1'b1;
	logic [7:0]           rx_reg = '0;

	result_t tick_results_q [$];
	result_t got, want;
	int      err_cnt = 0;
	int      cycles = 0;
	int      sent_ticks = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{TIM_KEEP,   ACT_NONE,  8'h00, 8'h00, 1'b1, 1'b1, 8'h00},
		'{TIM_ZERO,   ACT_RESET, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00},
		'{TIM_KEEP,   ACT_WRITE, 8'hA5, 8'hFF, 1'b0, 1'b0, 8'h00},
		'{TIM_KEEP,   ACT_READ,  8'h00, 8'h3C, 1'b1, 1'b0, 8'h3C},
		'{TIM_KEEP,   ACT_RESET, 8'h00, 8'hFF, 1'b1, 1'b1, 8'h3C},
		'{TIM_KEEP,   ACT_WRITE, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
		'{TIM_KEEP,   ACT_WRITE, 8'hFF, 8'h00, 1'b0, 1'b0, 8'h00},
		'{TIM_KEEP,   ACT_READ,  8'h00, 8'hFF, 1'b1, 1'b1, 8'hFF},
		'{TIM_KEEP,   ACT_READ,  8'hFF, 8'h00, 1'b1, 1'b1, 8'h00},
		'{TIM_KEEP,   ACT_READ,  8'h00, 8'h5A, 1'b1, 1'b1, 8'h5A},
		'{TIM_KEEP,   ACT_NONE,  8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00},
		'{TIM_RANDOM, ACT_RESET, 8'h00, 8'h00, 1'b1, 1'b0, 8'h5A},
		'{TIM_KEEP,   ACT_WRITE, 8'h96, 8'hFF, 1'b0, 1'b0, 8'h00},
		'{TIM_KEEP,   ACT_READ,  8'h00, 8'h81, 1'b1, 1'b0, 8'h81}
	};

	one_wire_bus_master_core #(
		.TICK_COUNT_WIDTH(TICK_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.tx_byte(tx_byte),
		.line_level(line_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.drive_low(drive_low),
		.busy_res(busy_res),
		.done_res(done_res),
		.presence_level(presence_level),
		.rx_byte(rx_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int slot_len(input logic [CFG_INDEX_WIDTH-1:0] idx);
		return (tim_reg[idx] == '0) ? 1 : int'(tim_reg[idx]);
	endfunction

	// one tick of the bus sequencer
	task automatic advance_bus_tick(input logic [1:0] act, input logic [7:0] tx,
			input logic line, output result_t r);
		int   len;
		logic drv, fin, rst_k, wr_k;
		drv = 1'b0;
		fin = 1'b0;
		len = 1;
		if (bus_ph == PH_IDLE && act != ACT_NONE) begin
			cmd_kind = act;
			shift_reg = (act == ACT_WRITE) ? tx : 8'h00;
			slot_bit = '0;
			tick_cnt = 0;
			bus_ph = PH_LOW;
		end
		if (bus_ph != PH_IDLE) begin
			rst_k = (cmd_kind == ACT_RESET);
			wr_k = (cmd_kind == ACT_WRITE);
			case (bus_ph)
				PH_LOW: begin
					drv = 1'b1;
					len = rst_k ? slot_len(REG_RESET_LOW) :
						wr_k ? slot_len(REG_WRITE_LOW) : slot_len(REG_READ_LOW);
				end
				PH_HOLD: begin
					drv = ~shift_reg[slot_bit];
					len = slot_len(REG_WRITE_HOLD);
				end
				PH_WAIT: begin
					len = rst_k ? slot_len(REG_PRESENCE_WAIT) : slot_len(REG_READ_SAMPLE);
				end
				default: begin
					len = rst_k ? slot_len(REG_RESET_RECOVER) : slot_len(REG_READ_RECOVER);
					// sample on the first recovery tick only
					if (tick_cnt == 0) begin
						if (rst_k)
							pres_reg = line;
						else
							shift_reg[slot_bit] = shift_reg[slot_bit] | line;
					end
				end
			endcase
			if (tick_cnt + 1 < len && tick_cnt < TICK_MAX) begin
				tick_cnt++;
			end else begin
				tick_cnt = 0;
				case (bus_ph)
					PH_LOW: bus_ph = wr_k ? PH_HOLD : PH_WAIT;
					PH_HOLD: begin
						if (slot_bit == 3'd7) begin
							bus_ph = PH_IDLE;
							fin = 1'b1;
						end else begin
							slot_bit++;
							bus_ph = PH_LOW;
						end
					end
					PH_WAIT: bus_ph = PH_RECOVER;
					default: begin
						if (rst_k) begin
							bus_ph = PH_IDLE;
							fin = 1'b1;
						end else if (slot_bit == 3'd7) begin
							rx_reg = shift_reg;
							bus_ph = PH_IDLE;
							fin = 1'b1;
						end else begin
							slot_bit++;
							bus_ph = PH_LOW;
						end
					end
				endcase
			end
		end
		r.drive_low = drv;
		r.busy = (bus_ph != PH_IDLE);
		r.done = fin;
		r.presence = pres_reg;
		r.rx_byte = rx_reg;
	endtask

	task automatic flag_mismatch(input string what, input result_t w, input result_t g);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0t %s: want drv %0b busy %0b done %0b pres %0b rx %02h, %s",
				$realtime, what, w.drive_low, w.busy, w.done, w.presence, w.rx_byte,
				$sformatf("got drv %0b busy %0b done %0b pres %0b rx %02h",
					g.drive_low, g.busy, g.done, g.presence, g.rx_byte));
	endtask

	// send one tick request; typed values replace presence and rx on the final tick
	task automatic send_tick(input logic [1:0] act, input logic [7:0] tx, input logic line,
			input bit typed, input logic tp, input logic [7:0] trx);
		result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		advance_bus_tick(act, tx, line, r);
		if (typed && !r.busy) begin
			r.presence = tp;
			r.rx_byte = trx;
		end
		tick_results_q.push_back(r);
		in_valid <= 1'b1;
		action <= act;
		tx_byte <= tx;
		line_level <= line;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_ticks++;
	endtask

	// a command from its accepting tick until the sequencer is idle again
	task automatic run_command(input logic [1:0] act, input logic [7:0] tx,
			input logic [7:0] pat, input bit noisy, input bit typed, input logic tp,
			input logic [7:0] trx);
		logic [1:0] a;
		logic [7:0] b;
		logic       ln;
		a = act;
		b = tx;
		do begin
			ln = noisy ? 1'($urandom_range(1)) : pat[slot_bit];
			send_tick(a, b, ln, typed, tp, trx);
			// commands sent while busy must be dropped
			if (noisy) begin
				a = ($urandom_range(4) == 0) ? 2'($urandom_range(3)) : ACT_NONE;
				b = 8'($urandom);
			end else begin
				a = (act == ACT_READ) ? ACT_RESET : ACT_READ;
				b = ~tx;
			end
		end while (bus_ph != PH_IDLE);
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tick_results_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_timing(input timing_sel_t sel);
		logic [CFG_WIDTH-1:0] val;
		if (sel != TIM_KEEP) begin
			wait_quiet();
			for (int i = 0; i < CFG_COUNT; i++) begin
				case (sel)
					TIM_ZERO: val = '0;
					TIM_MAX: val = '1;
					default: begin
						// mostly short slots so that many commands fit in the run
						val = ($urandom_range(11) == 0) ? CFG_WIDTH'($urandom_range(5, 24)) :
							CFG_WIDTH'($urandom_range(3));
					end
				endcase
				cfg_valid <= 1'b1;
				cfg_index <= CFG_INDEX_WIDTH'(i);
				cfg_data <= val;
				@(posedge clk);
				while (!cfg_ready)
					@(posedge clk);
				tim_reg[i] = val;
			end
			cfg_valid <= 1'b0;
		end
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got = {drive_low, busy_res, done_res, presence_level, rx_byte};
			if (tick_results_q.size() == 0) begin
				flag_mismatch("unexpected result", '0, got);
			end else begin
				want = tick_results_q.pop_front();
				if (got !== want)
					flag_mismatch("result mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		tim_reg[REG_RESET_LOW] = RST_RESET_LOW;
		tim_reg[REG_PRESENCE_WAIT] = RST_PRESENCE_WAIT;
		tim_reg[REG_RESET_RECOVER] = RST_RESET_RECOVER;
		tim_reg[REG_WRITE_LOW] = RST_WRITE_LOW;
		tim_reg[REG_WRITE_HOLD] = RST_WRITE_HOLD;
		tim_reg[REG_READ_LOW] = RST_READ_LOW;
		tim_reg[REG_READ_SAMPLE] = RST_READ_SAMPLE;
		tim_reg[REG_READ_RECOVER] = RST_READ_RECOVER;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_NONE;
		tx_byte = '0;
		line_level = 1'b1;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 14;
		recv_stall_pct = 59;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			program_timing(dir_rows[i].sel);
			run_command(dir_rows[i].act, dir_rows[i].tx, dir_rows[i].pat, 1'b0,
				dir_rows[i].typed, dir_rows[i].t_pres, dir_rows[i].t_rx);
		end

		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 14 : (mode == 1) ? 59 : 0;
			recv_stall_pct = (mode == 0) ? 59 : (mode == 1) ? 14 : 0;
			repeat (1) begin
				int start;
				program_timing(TIM_RANDOM);
				start = sent_ticks;
				while (sent_ticks - start < 30) begin
					repeat ($urandom_range(2))
						send_tick(ACT_NONE, 8'($urandom), 1'($urandom_range(1)), 1'b0, 1'b0, 8'h00);
					run_command(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom), 1'b1,
						1'b0, 1'b0, 8'h00);
				end
			end
		end

		wait_quiet();
		repeat (8) @(posedge clk);
		if (err_cnt == 0 && tick_results_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== one_wire_bus_master_core.f =====
rtl/owm_pkg.sv
rtl/owm_cfg_regs.sv
rtl/owm_engine.sv
rtl/one_wire_bus_master_core.sv
rtl/owm_checker.sv
verif/tb_one_wire_bus_master_core.sv
